// ===== hdl/bbdr_pkg.sv =====
`default_nettype none

package bbdr_pkg;

  localparam int unsigned DutyW = 11;
  localparam logic [DutyW-1:0] DutyMax = 11'd1800;
  localparam logic [7:0] SyncDeadtime = 8'd16;
  localparam logic [7:0] SyncNone = 8'd255;

  localparam logic [1:0] RegVoltSetpoint = 2'd0;
  localparam logic [1:0] RegCurrentLimit = 2'd1;
  localparam logic [1:0] RegOverrideDuty = 2'd2;
  localparam logic [1:0] RegSupplyOff = 2'd3;

  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_ON  = 2'd1,
    DRIVE_PWM = 2'd2
  } drive_e;

  typedef struct packed {
    logic [15:0]        volt_setpoint;
    logic [15:0]        current_limit;
    logic signed [11:0] override_duty;
    logic               supply_off;
  } bbdr_cfg_t;

  typedef struct packed {
    drive_e     boost_low_drive;
    drive_e     boost_high_drive;
    drive_e     buck_low_drive;
    drive_e     buck_high_drive;
    logic       boost_mode;
    logic [7:0] sync_compare;
    logic [1:0] dither_bits;
    logic [7:0] duty_high;
  } bbdr_result_t;

endpackage

`default_nettype wire

// ===== hdl/bbdr_core.sv =====
`default_nettype none

module bbdr_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [15:0]           measured_mv_i,
  input  wire logic [15:0]           measured_current_i,
  input  wire bbdr_pkg::bbdr_cfg_t   cfg_i,
  output bbdr_pkg::bbdr_result_t     result_o
);
  import bbdr_pkg::*;

  logic [DutyW-1:0] duty_q, duty_d;
  logic [DutyW-1:0] duty_step;
  logic [DutyW-1:0] ovr_duty;
  logic             go_up, go_down;
  logic [8:0]       sync_sum;

  assign go_up   = (measured_mv_i < cfg_i.volt_setpoint) &&
                   (measured_current_i < cfg_i.current_limit);
  assign go_down = (measured_mv_i > cfg_i.volt_setpoint) ||
                   (measured_current_i > cfg_i.current_limit);

  always_comb begin
    duty_step = duty_q;
    if (go_up) begin
      duty_step = (duty_q < DutyMax) ? duty_q + 1'b1 : DutyMax;
    end else if (go_down) begin
      duty_step = (duty_q != '0) ? duty_q - 1'b1 : '0;
    end
    ovr_duty = cfg_i.override_duty[DutyW-1:0];
    if (ovr_duty > DutyMax) begin
      ovr_duty = DutyMax;
    end
    duty_d = cfg_i.override_duty[11] ? duty_step : ovr_duty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
    end else if (step_i) begin
      duty_q <= duty_d;
    end
  end

  // duty below 1024 keeps bit 10 clear, above it bit 10 is the boost offset
  assign sync_sum = {1'b0, duty_d[9:2]} + {1'b0, SyncDeadtime};

  always_comb begin
    result_o.duty_high   = duty_d[9:2];
    result_o.dither_bits = duty_d[1:0];
    result_o.boost_mode  = duty_d[10];
    if (duty_d[10] || sync_sum[8]) begin
      result_o.sync_compare = SyncNone;
    end else begin
      result_o.sync_compare = sync_sum[7:0];
    end
    if (cfg_i.supply_off) begin
      result_o.buck_high_drive  = DRIVE_OFF;
      result_o.buck_low_drive   = DRIVE_OFF;
      result_o.boost_high_drive = DRIVE_OFF;
      result_o.boost_low_drive  = DRIVE_OFF;
    end else if (duty_d[10]) begin
      result_o.buck_high_drive  = DRIVE_ON;
      result_o.buck_low_drive   = DRIVE_OFF;
      result_o.boost_high_drive = DRIVE_PWM;
      result_o.boost_low_drive  = DRIVE_PWM;
    end else begin
      result_o.buck_high_drive  = DRIVE_PWM;
      result_o.buck_low_drive   = DRIVE_PWM;
      result_o.boost_high_drive = DRIVE_ON;
      result_o.boost_low_drive  = DRIVE_OFF;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/buck_boost_duty_regulator_unit.sv =====
// Bang-bang duty regulator for a four-switch buck/boost stage. Each input word
// is one control tick: the stored duty (0..1800) steps up, down or holds from
// the voltage and current readings, a non-negative override replaces it, and
// one result word carries the PWM compare, dither bits, sync compare, mode and
// switch drives. One word per cycle is sustained while the sink keeps up; each
// result is registered. A two-entry output stage (result register plus
// skid register) takes one more word after the sink stalls, so s_axis_tready
// comes straight from a register; while the skid register is full the input
// is held off.
// Configuration must be written only while the block is idle (not enforced).
`default_nettype none

module buck_boost_duty_regulator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] measured_mv, [31:16] measured_current
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] duty_high, [9:8] dither_bits, [17:10] sync_compare, [18] boost_mode,
  // [20:19] buck_high_drive, [22:21] buck_low_drive, [24:23] boost_high_drive,
  // [26:25] boost_low_drive, [31:27] zero
  output logic [31:0]      m_axis_tdata
);
  import bbdr_pkg::*;

  bbdr_cfg_t    cfg_q;
  bbdr_result_t result;
  bbdr_result_t out_q, out_d, skid_q, skid_d;
  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic         in_fire, out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_setpoint <= '0;
      cfg_q.current_limit <= '0;
      cfg_q.override_duty <= '1;
      cfg_q.supply_off    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegVoltSetpoint: cfg_q.volt_setpoint <= cfg_wdata_i;
        RegCurrentLimit: cfg_q.current_limit <= cfg_wdata_i;
        RegOverrideDuty: cfg_q.override_duty <= cfg_wdata_i[11:0];
        RegSupplyOff:    cfg_q.supply_off    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  bbdr_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (in_fire),
    .measured_mv_i      (s_axis_tdata[15:0]),
    .measured_current_i (s_axis_tdata[31:16]),
    .cfg_i              (cfg_q),
    .result_o           (result)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.boost_low_drive, out_q.boost_high_drive,
                          out_q.buck_low_drive, out_q.buck_high_drive,
                          out_q.boost_mode, out_q.sync_compare,
                          out_q.dither_bits, out_q.duty_high};

endmodule

`default_nettype wire
